@@ hdl/sbsm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_pkg
// Shared types, codes and helpers for the serial bank-switch mapper.
// ---------------------------------------------------------------------------
package sbsm_pkg;

  // Access kinds on the input channel.
  localparam logic [1:0] FUNC_CPU_READ  = 2'd0;
  localparam logic [1:0] FUNC_CPU_WRITE = 2'd1;
  localparam logic [1:0] FUNC_PPU_READ  = 2'd2;
  localparam logic [1:0] FUNC_PPU_WRITE = 2'd3;

  // Memory targets.
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_RAM = 2'd1;
  localparam logic [1:0] TGT_PRG_ROM = 2'd2;
  localparam logic [1:0] TGT_CHR     = 2'd3;

  // Mirroring modes.
  localparam logic [1:0] MIRROR_ONE_LOWER = 2'd0;
  localparam logic [1:0] MIRROR_ONE_UPPER = 2'd1;
  localparam logic [1:0] MIRROR_VERT      = 2'd2;
  localparam logic [1:0] MIRROR_HORIZ     = 2'd3;

  // Serial register select, address bits 14:13.
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // PRG banking modes, control bits 3:2.
  localparam logic [1:0] PRG_MODE_32K_A   = 2'd0;
  localparam logic [1:0] PRG_MODE_32K_B   = 2'd1;
  localparam logic [1:0] PRG_MODE_FIX_LOW = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HI  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PRG_BANK_COUNT = 2'd0;
  localparam logic [1:0] REG_HEADER_MIRROR  = 2'd1;

  localparam logic [5:0] PRG_BANK_COUNT_RST = 6'd16;
  localparam logic [4:0] CONTROL_RST        = 5'h1c;
  localparam logic [4:0] PRG_MODE3_BITS     = 5'h0c;
  localparam logic [2:0] LAST_SHIFT_COUNT   = 3'd4;
  localparam logic [5:0] MAX_PRG_BANKS      = 6'd32;

  typedef struct packed {
    logic [4:0] prg_low;
    logic [4:0] prg_high;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic       ram_disabled;
  } bank_state_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [18:0] target_addr;
    logic        target_write;
    logic [7:0]  target_data;
    logic        accepted;
    logic [1:0]  mirror_mode;
  } result_t;

  // Index of the last 16 KB bank, with the count clamped to 1..32.
  function automatic logic [4:0] last_bank(input logic [5:0] count);
    logic [5:0] n;
    begin
      n = count;
      if (n == 6'd0) begin
        n = 6'd1;
      end else if (n > MAX_PRG_BANKS) begin
        n = MAX_PRG_BANKS;
      end
      last_bank = 5'(n - 6'd1);
    end
  endfunction

  function automatic logic [1:0] header_mirror(input logic vertical);
    header_mirror = vertical ? MIRROR_VERT : MIRROR_HORIZ;
  endfunction

endpackage

@@ hdl/sbsm_regs.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_regs
// Serial load, control, bank and configuration registers. Configuration
// writes win; otherwise state moves on when a request is accepted.
// ---------------------------------------------------------------------------
module sbsm_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data,
  input  logic                 req_accept,
  input  logic [1:0]           req_func,
  input  logic [15:0]          req_addr,
  input  logic [7:0]           req_data,
  output sbsm_pkg::bank_state_t banks,
  output logic [1:0]           mirror_nxt,
  output logic                 reg_accepted
);

  logic [5:0] prg_bank_count_r;
  logic [4:0] shift_r, shift_nxt;
  logic [2:0] count_r, count_nxt;
  logic [4:0] control_r, control_nxt;
  logic [1:0] mirror_r;
  sbsm_pkg::bank_state_t banks_r, banks_nxt;
  logic [4:0] shift_in;
  logic       reg_write;

  assign shift_in  = {req_data[0], shift_r[4:1]};
  assign reg_write = (req_func == sbsm_pkg::FUNC_CPU_WRITE) && req_addr[15];
  assign reg_accepted = !req_data[7];

  always_comb begin
    shift_nxt   = shift_r;
    count_nxt   = count_r;
    control_nxt = control_r;
    mirror_nxt  = mirror_r;
    banks_nxt   = banks_r;
    if (reg_write) begin
      if (req_data[7]) begin
        shift_nxt   = '0;
        count_nxt   = '0;
        control_nxt = control_r | sbsm_pkg::PRG_MODE3_BITS;
      end else if (count_r < sbsm_pkg::LAST_SHIFT_COUNT) begin
        shift_nxt = shift_in;
        count_nxt = count_r + 3'd1;
      end else begin
        // Fifth write: the collected value goes to the selected register.
        shift_nxt = '0;
        count_nxt = '0;
        case (req_addr[14:13])
          sbsm_pkg::SEL_CONTROL: begin
            control_nxt = shift_in;
            mirror_nxt  = shift_in[1:0];
          end
          sbsm_pkg::SEL_CHR0: begin
            if (control_r[4]) begin
              banks_nxt.chr_low = shift_in;
            end else begin
              banks_nxt.chr_low  = {shift_in[4:1], 1'b0};
              banks_nxt.chr_high = {shift_in[4:1], 1'b1};
            end
            banks_nxt.ram_disabled = shift_in[4];
          end
          sbsm_pkg::SEL_CHR1: begin
            // In 8 KB mode the second CHR register is ignored.
            if (control_r[4]) begin
              banks_nxt.chr_high     = shift_in;
              banks_nxt.ram_disabled = shift_in[4];
            end
          end
          default: begin
            case (control_r[3:2])
              sbsm_pkg::PRG_MODE_32K_A, sbsm_pkg::PRG_MODE_32K_B: begin
                banks_nxt.prg_low  = {1'b0, shift_in[3:1], 1'b0};
                banks_nxt.prg_high = {1'b0, shift_in[3:1], 1'b1};
              end
              sbsm_pkg::PRG_MODE_FIX_LOW: begin
                banks_nxt.prg_low  = '0;
                banks_nxt.prg_high = {1'b0, shift_in[3:0]};
              end
              default: begin
                banks_nxt.prg_low  = {1'b0, shift_in[3:0]};
                banks_nxt.prg_high = sbsm_pkg::last_bank(prg_bank_count_r);
              end
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_count_r <= sbsm_pkg::PRG_BANK_COUNT_RST;
      shift_r   <= '0;
      count_r   <= '0;
      control_r <= sbsm_pkg::CONTROL_RST;
      mirror_r  <= sbsm_pkg::header_mirror(1'b0);
      banks_r.prg_low      <= '0;
      banks_r.prg_high     <= sbsm_pkg::last_bank(sbsm_pkg::PRG_BANK_COUNT_RST);
      banks_r.chr_low      <= '0;
      banks_r.chr_high     <= '0;
      banks_r.ram_disabled <= 1'b0;
    end else if (cfg_valid) begin
      // The user must write configuration only while no request is in flight; the block does not enforce this.
      case (cfg_index)
        sbsm_pkg::REG_PRG_BANK_COUNT: begin
          prg_bank_count_r <= cfg_data;
          banks_r.prg_high <= sbsm_pkg::last_bank(cfg_data);
        end
        sbsm_pkg::REG_HEADER_MIRROR: begin
          mirror_r <= sbsm_pkg::header_mirror(cfg_data[0]);
        end
        default: begin
        end
      endcase
    end else if (req_accept) begin
      shift_r   <= shift_nxt;
      count_r   <= count_nxt;
      control_r <= control_nxt;
      mirror_r  <= mirror_nxt;
      banks_r   <= banks_nxt;
    end
  end

  assign banks = banks_r;

endmodule

@@ hdl/sbsm_xlate.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_xlate
// Address translation: decodes one request against the current bank state
// and builds the result item.
// ---------------------------------------------------------------------------
module sbsm_xlate (
  input  logic [1:0]            req_func,
  input  logic [15:0]           req_addr,
  input  logic [7:0]            req_data,
  input  sbsm_pkg::bank_state_t banks,
  input  logic [1:0]            mirror_nxt,
  input  logic                  reg_accepted,
  output sbsm_pkg::result_t     result
);

  logic       is_write;
  logic [4:0] chr_bank;
  logic [4:0] prg_bank;

  assign is_write = req_func[0];
  assign chr_bank = req_addr[12] ? banks.chr_high : banks.chr_low;
  assign prg_bank = req_addr[14] ? banks.prg_high : banks.prg_low;

  always_comb begin
    result.target      = sbsm_pkg::TGT_NONE;
    result.target_addr = '0;
    result.accepted    = 1'b0;
    if (req_func[1]) begin
      result.target      = sbsm_pkg::TGT_CHR;
      result.target_addr = {2'b00, chr_bank, req_addr[11:0]};
      result.accepted    = 1'b1;
    end else if (req_addr < 16'h6000) begin
      result.accepted = 1'b0;
    end else if (!req_addr[15]) begin
      if (!banks.ram_disabled) begin
        result.target      = sbsm_pkg::TGT_PRG_RAM;
        result.target_addr = {6'd0, req_addr[12:0]};
        result.accepted    = 1'b1;
      end
    end else if (is_write) begin
      result.accepted = reg_accepted;
    end else begin
      result.target      = sbsm_pkg::TGT_PRG_ROM;
      result.target_addr = {prg_bank, req_addr[13:0]};
      result.accepted    = 1'b1;
    end
    result.target_write = (result.target != sbsm_pkg::TGT_NONE) && is_write;
    result.target_data  = result.target_write ? req_data : 8'd0;
    result.mirror_mode  = mirror_nxt;
  end

endmodule

@@ hdl/serial_bank_switch_mapper.sv @@
`timescale 1ns / 1ps
// A result is registered and shows the cycle after its request is accepted.
// Throughput: one request per cycle when not stalled; the output register
// frees as it is taken. A stalled result holds there while ready is low.
// Synchronous active-low reset restores bank, control and configuration
// registers to their power-on values and empties the output register.
// ---------------------------------------------------------------------------
// serial_bank_switch_mapper
// Cartridge bank-switch mapper with a serially loaded register set and
// CPU/PPU address translation.
// ---------------------------------------------------------------------------
module serial_bank_switch_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_bus_addr,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_target,
  output logic [18:0] out_target_addr,
  output logic        out_target_write,
  output logic [7:0]  out_target_data,
  output logic        out_accepted,
  output logic [1:0]  out_mirror_mode
);

  sbsm_pkg::bank_state_t banks;
  sbsm_pkg::result_t     result;
  sbsm_pkg::result_t     result_r;
  logic [1:0] mirror_nxt;
  logic       reg_accepted;
  logic       req_accept;
  logic       out_valid_r;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !out_valid_r || out_ready;
  assign req_accept = in_valid && in_ready;

  sbsm_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_accept   (req_accept),
    .req_func     (in_func),
    .req_addr     (in_bus_addr),
    .req_data     (in_write_data),
    .banks        (banks),
    .mirror_nxt   (mirror_nxt),
    .reg_accepted (reg_accepted)
  );

  sbsm_xlate u_xlate (
    .req_func     (in_func),
    .req_addr     (in_bus_addr),
    .req_data     (in_write_data),
    .banks        (banks),
    .mirror_nxt   (mirror_nxt),
    .reg_accepted (reg_accepted),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      result_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target       = result_r.target;
  assign out_target_addr  = result_r.target_addr;
  assign out_target_write = result_r.target_write;
  assign out_target_data  = result_r.target_data;
  assign out_accepted     = result_r.accepted;
  assign out_mirror_mode  = result_r.mirror_mode;

endmodule

@@ hdl/sbsm_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsm_checker
// Port-level checks on the mapper, bound to the top level.
// ---------------------------------------------------------------------------
module sbsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [5:0]  cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic [15:0] in_bus_addr,
  input logic [7:0]  in_write_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_target,
  input logic [18:0] out_target_addr,
  input logic        out_target_write,
  input logic [7:0]  out_target_data,
  input logic        out_accepted,
  input logic [1:0]  out_mirror_mode
);

  // An accepted request always yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // A stalled result holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target)
      && $stable(out_target_addr) && $stable(out_mirror_mode))
    else $error("stalled result changed");

  // A refused access never reaches a memory.
  a_refused_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_target == sbsm_pkg::TGT_NONE)
    else $error("refused access has a target");

  // With no target, address, write flag and data are all zero.
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target == sbsm_pkg::TGT_NONE |->
      out_target_addr == 19'd0 && !out_target_write && out_target_data == 8'd0)
    else $error("untargeted result carries address or data");

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (.*);
